// ----- src/quadrature_detent_decoder_core_assert.svh -----
// Assertion macros used by the checker of the detent decoder.
`ifndef QUADRATURE_DETENT_DECODER_CORE_ASSERT_SVH
`define QUADRATURE_DETENT_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define QDD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define QDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/qdd_pkg.sv -----
// Package with types and constants of the quadrature detent decoder.
package qdd_pkg;

   // Phase codes of the detent sequence.
   localparam logic [2:0] PH_WAIT   = 3'd0;
   localparam logic [2:0] PH_FIRST  = 3'd1;
   localparam logic [2:0] PH_MIDDLE = 3'd2;
   localparam logic [2:0] PH_LAST   = 3'd3;
   localparam logic [2:0] PH_RESYNC = 3'd4;

   // Step event codes.
   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_FWD  = 2'd1;
   localparam logic [1:0] EV_REV  = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SETTLE_TICKS   = 3'd0;
   localparam logic [2:0] CSR_WAIT_LIMIT     = 3'd1;
   localparam logic [2:0] CSR_CODE_IDLE      = 3'd2;
   localparam logic [2:0] CSR_CODE_FIRST_FWD = 3'd3;
   localparam logic [2:0] CSR_CODE_FIRST_REV = 3'd4;
   localparam logic [2:0] CSR_CODE_MIDDLE    = 3'd5;
   localparam logic [2:0] CSR_CODE_LAST_FWD  = 3'd6;
   localparam logic [2:0] CSR_CODE_LAST_REV  = 3'd7;

   // Reset values of the configuration registers.
   localparam logic [15:0] RST_SETTLE_TICKS   = 16'd10;
   localparam logic [7:0]  RST_WAIT_LIMIT     = 8'd15;
   localparam logic [1:0]  RST_CODE_IDLE      = 2'd3;
   localparam logic [1:0]  RST_CODE_FIRST_FWD = 2'd2;
   localparam logic [1:0]  RST_CODE_FIRST_REV = 2'd1;
   localparam logic [1:0]  RST_CODE_MIDDLE    = 2'd0;
   localparam logic [1:0]  RST_CODE_LAST_FWD  = 2'd1;
   localparam logic [1:0]  RST_CODE_LAST_REV  = 2'd2;

   // Input transaction payload.
   typedef struct packed {
      logic [1:0] sample_code;
      logic       tick;
   } req_payload_type;

   // Result transaction payload.
   typedef struct packed {
      logic signed [31:0] position;
      logic [1:0]         step_event;
      logic [2:0]         phase_now;
   } rsp_payload_type;

endpackage

// ----- src/quadrature_detent_decoder_core.sv -----
// Latency: a result appears in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle unless the result side stalls; the phase logic
// and the position adder sit between the state and result registers in one pass.
// An input is stalled only while a result waits and the result side stalls.
// Synchronous active-high reset returns the wait phase, a zero position and the
// documented register defaults.
module quadrature_detent_decoder_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  qdd_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output qdd_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_we,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_wdata
);

   // Configuration registers.
   logic [15:0] settle_ticks_ff;
   logic [7:0]  wait_limit_ff;
   logic [1:0]  code_idle_ff, code_first_fwd_ff, code_first_rev_ff;
   logic [1:0]  code_middle_ff, code_last_fwd_ff, code_last_rev_ff;

   // Decoder state.
   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  prev_code_ff, prev_code_in;
   logic        fwd_flag_ff, fwd_flag_in;
   logic        rev_flag_ff, rev_flag_in;
   logic [7:0]  wait_count_ff, wait_count_in;
   logic [15:0] settle_left_ff, settle_left_in;
   logic        settling_ff, settling_in;
   logic [31:0] count_ff, count_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   qdd_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic       req_take;
   logic       changed;
   logic       start_dly;
   logic       waited;
   logic [8:0] wait_inc;
   logic [1:0] event_code;

   // Accept whenever the result register is empty or being drained.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign changed   = (req_data.sample_code != prev_code_ff);
   assign wait_inc  = {1'b0, wait_count_ff} + 9'd1;

   // Next state of the detent sequence for the transaction at the input.
   always_comb begin
      phase_in       = phase_ff;
      prev_code_in   = prev_code_ff;
      fwd_flag_in    = fwd_flag_ff;
      rev_flag_in    = rev_flag_ff;
      wait_count_in  = wait_count_ff;
      settle_left_in = settle_left_ff;
      settling_in    = settling_ff;
      count_in       = count_ff;
      event_code     = qdd_pkg::EV_NONE;
      start_dly      = 1'b0;
      waited         = 1'b0;

      if (settling_ff) begin
         if (req_data.tick) begin
            settle_left_in = settle_left_ff - 16'd1;
            if (settle_left_ff == 16'd1) begin
               settling_in = 1'b0;
            end
         end
      end else begin
         unique case (phase_ff)
            qdd_pkg::PH_WAIT: begin
               if (changed) begin
                  if (req_data.sample_code == code_first_rev_ff) begin
                     phase_in    = qdd_pkg::PH_FIRST;
                     rev_flag_in = 1'b1;
                  end else if (req_data.sample_code == code_first_fwd_ff) begin
                     phase_in    = qdd_pkg::PH_FIRST;
                     fwd_flag_in = 1'b1;
                  end else begin
                     phase_in    = qdd_pkg::PH_RESYNC;
                     fwd_flag_in = 1'b0;
                     rev_flag_in = 1'b0;
                  end
                  wait_count_in = '0;
                  prev_code_in  = req_data.sample_code;
                  start_dly     = 1'b1;
               end
            end
            qdd_pkg::PH_FIRST: begin
               if (!changed) begin
                  waited = 1'b1;
               end else begin
                  wait_count_in = '0;
                  prev_code_in  = req_data.sample_code;
                  start_dly     = 1'b1;
                  if (req_data.sample_code == code_middle_ff) begin
                     phase_in = qdd_pkg::PH_MIDDLE;
                  end else begin
                     phase_in    = qdd_pkg::PH_RESYNC;
                     fwd_flag_in = 1'b0;
                     rev_flag_in = 1'b0;
                  end
               end
            end
            qdd_pkg::PH_MIDDLE: begin
               if (!changed) begin
                  waited = 1'b1;
               end else begin
                  // A last code of the wrong direction keeps the middle phase.
                  if (req_data.sample_code == code_last_rev_ff) begin
                     if (rev_flag_ff) begin
                        phase_in  = qdd_pkg::PH_LAST;
                        start_dly = 1'b1;
                     end
                  end else if (req_data.sample_code == code_last_fwd_ff) begin
                     if (fwd_flag_ff) begin
                        phase_in  = qdd_pkg::PH_LAST;
                        start_dly = 1'b1;
                     end
                  end else begin
                     phase_in    = qdd_pkg::PH_RESYNC;
                     fwd_flag_in = 1'b0;
                     rev_flag_in = 1'b0;
                  end
                  prev_code_in  = req_data.sample_code;
                  wait_count_in = '0;
               end
            end
            qdd_pkg::PH_LAST: begin
               if (!changed) begin
                  waited = 1'b1;
               end else begin
                  if (rev_flag_ff) begin
                     count_in   = count_ff - 32'd1;
                     event_code = qdd_pkg::EV_REV;
                  end else if (fwd_flag_ff) begin
                     count_in   = count_ff + 32'd1;
                     event_code = qdd_pkg::EV_FWD;
                  end
                  fwd_flag_in   = 1'b0;
                  rev_flag_in   = 1'b0;
                  prev_code_in  = req_data.sample_code;
                  wait_count_in = '0;
                  phase_in      = qdd_pkg::PH_WAIT;
               end
            end
            qdd_pkg::PH_RESYNC: begin
               if (changed) begin
                  if (req_data.sample_code == code_idle_ff) begin
                     phase_in = qdd_pkg::PH_WAIT;
                  end
                  prev_code_in = req_data.sample_code;
               end
               start_dly = 1'b1;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase

         // An unchanged code counts one wait period; too many give up the sequence.
         if (waited) begin
            if (wait_inc > {1'b0, wait_limit_ff}) begin
               wait_count_in = '0;
               phase_in      = qdd_pkg::PH_RESYNC;
               fwd_flag_in   = 1'b0;
               rev_flag_in   = 1'b0;
            end else begin
               wait_count_in = wait_inc[7:0];
               start_dly     = 1'b1;
            end
         end

         // A zero settle time enters no delay at all.
         if (start_dly && (settle_ticks_ff != 16'd0)) begin
            settle_left_in = settle_ticks_ff;
            settling_in    = 1'b1;
         end
      end
   end

   // Result register: load on an accepted transaction, clear when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_take) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.position   = count_in;
         rsp_data_in.step_event = event_code;
         rsp_data_in.phase_now  = phase_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff   <= qdd_pkg::RST_SETTLE_TICKS;
         wait_limit_ff     <= qdd_pkg::RST_WAIT_LIMIT;
         code_idle_ff      <= qdd_pkg::RST_CODE_IDLE;
         code_first_fwd_ff <= qdd_pkg::RST_CODE_FIRST_FWD;
         code_first_rev_ff <= qdd_pkg::RST_CODE_FIRST_REV;
         code_middle_ff    <= qdd_pkg::RST_CODE_MIDDLE;
         code_last_fwd_ff  <= qdd_pkg::RST_CODE_LAST_FWD;
         code_last_rev_ff  <= qdd_pkg::RST_CODE_LAST_REV;
      end else if (csr_we) begin
         unique case (csr_index)
            qdd_pkg::CSR_SETTLE_TICKS:   settle_ticks_ff   <= csr_wdata;
            qdd_pkg::CSR_WAIT_LIMIT:     wait_limit_ff     <= csr_wdata[7:0];
            qdd_pkg::CSR_CODE_IDLE:      code_idle_ff      <= csr_wdata[1:0];
            qdd_pkg::CSR_CODE_FIRST_FWD: code_first_fwd_ff <= csr_wdata[1:0];
            qdd_pkg::CSR_CODE_FIRST_REV: code_first_rev_ff <= csr_wdata[1:0];
            qdd_pkg::CSR_CODE_MIDDLE:    code_middle_ff    <= csr_wdata[1:0];
            qdd_pkg::CSR_CODE_LAST_FWD:  code_last_fwd_ff  <= csr_wdata[1:0];
            qdd_pkg::CSR_CODE_LAST_REV:  code_last_rev_ff  <= csr_wdata[1:0];
            default:                     settle_ticks_ff   <= settle_ticks_ff;
         endcase
      end
   end

   // Decoder state advances on each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= qdd_pkg::PH_WAIT;
         prev_code_ff   <= '0;
         fwd_flag_ff    <= 1'b0;
         rev_flag_ff    <= 1'b0;
         wait_count_ff  <= '0;
         settle_left_ff <= '0;
         settling_ff    <= 1'b0;
         count_ff       <= '0;
      end else if (req_take) begin
         phase_ff       <= phase_in;
         prev_code_ff   <= prev_code_in;
         fwd_flag_ff    <= fwd_flag_in;
         rev_flag_ff    <= rev_flag_in;
         wait_count_ff  <= wait_count_in;
         settle_left_ff <= settle_left_in;
         settling_ff    <= settling_in;
         count_ff       <= count_in;
      end
   end

   // Result valid under reset; payload has none.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/qdd_checker.sv -----
// Port-level checker for the detent decoder and its bind statement.
`include "quadrature_detent_decoder_core_assert.svh"

module qdd_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input qdd_pkg::rsp_payload_type rsp_data
);

   logic req_take;
   logic step_seen;
   logic phase_wait;
   logic event_ok;
   logic rsp_wait;

   // Port conditions the properties below refer to.
   assign req_take   = req_valid && !req_stall;
   assign step_seen  = rsp_valid && (rsp_data.step_event != qdd_pkg::EV_NONE);
   assign phase_wait = (rsp_data.phase_now == qdd_pkg::PH_WAIT);
   assign event_ok   = (rsp_data.step_event == qdd_pkg::EV_NONE) ||
                       (rsp_data.step_event == qdd_pkg::EV_FWD) ||
                       (rsp_data.step_event == qdd_pkg::EV_REV);
   assign rsp_wait   = rsp_valid && rsp_stall;

   // Every accepted transaction yields a result in the next cycle.
   `QDD_ASSERT_NEXT(a_result_follows, clock, reset, req_take, rsp_valid, "no result after accept")

   // A counted step always returns the sequence to the wait phase.
   `QDD_ASSERT_NOW(a_step_ends_wait, clock, reset, step_seen, phase_wait, "step outside wait")

   // A valid result carries only a defined step event code.
   `QDD_ASSERT_NOW(a_event_legal, clock, reset, rsp_valid, event_ok, "bad step event code")

   // A stalled result holds its contents.
   `QDD_ASSERT_NEXT(a_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data), "payload moved")

endmodule

bind quadrature_detent_decoder_core qdd_checker u_qdd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
